[src/ocam_pkg.sv]
`default_nettype none

package ocam_pkg;

    localparam int PITCH_LIMIT = 16202;
    localparam int DIST_MIN = 51;
    localparam int DIST_MAX = 1024000;
    localparam int ATAN_LEN = 24;
    localparam int ATAN_IDX_W = 5;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

    typedef enum logic [2:0] {
        CFG_TARGET_X,
        CFG_TARGET_Y,
        CFG_TARGET_Z,
        CFG_START_DISTANCE,
        CFG_SPIN_RATE
    } cfg_index_t;

    // arctan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // clamp a signed distance to the legal Q10.10 range
    function automatic logic [19:0] clamp_dist(input logic signed [21:0] v);
        logic [19:0] r;
        if (v < 22'sd51)
            r = 20'(DIST_MIN);
        else if (v > 22'sd1024000)
            r = 20'(DIST_MAX);
        else
            r = v[19:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[src/orbit_camera_eye_position_top.sv]
// Orbit camera eye position: one CORDIC rotator shared by yaw and pitch, one multiplier.
// A request is accepted only in S_IDLE; in_stall stays high through the two serial CORDIC
// passes, the five products through the single multiplier and any wait for the output slot.
// Reset (rst_n, async, active low): yaw and pitch zero, distance 10.0, targets and spin zero.
`default_nettype none

module orbit_camera_eye_position_top
    import ocam_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] yaw_delta,
    input  wire logic signed [15:0] pitch_delta,
    input  wire logic signed [20:0] zoom_delta,
    input  wire logic        [15:0] elapsed,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      eye_x,
    output logic signed [31:0]      eye_y,
    output logic signed [31:0]      eye_z,
    output logic        [15:0]      yaw_now,
    output logic signed [14:0]      pitch_now,
    output logic        [19:0]      distance_now,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [31:0] cfg_data
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam int NUM_PROD = 5;
    localparam logic [2:0] MUL_DONE = 3'(NUM_PROD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_LOAD,
        S_ROT,
        S_STORE,
        S_MUL,
        S_SUM
    } state_t;

    state_t state_reg;

    // configuration and orbit state
    logic signed [31:0] target_x_reg;
    logic signed [31:0] target_y_reg;
    logic signed [31:0] target_z_reg;
    logic signed [15:0] spin_rate_reg;
    logic        [15:0] yaw_reg;
    logic signed [14:0] pitch_reg;
    logic        [19:0] dist_reg;

    // sequencer counters
    logic [STEP_W-1:0] step_reg;
    logic              pass_reg;
    logic [2:0]        mul_cnt_reg;

    // latched request
    logic signed [15:0] yd_reg;
    logic signed [15:0] pd_reg;
    logic signed [20:0] dd_reg;
    logic        [15:0] el_reg;

    // CORDIC datapath
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic signed [32:0] sy_reg;
    logic signed [32:0] cy_reg;
    logic signed [32:0] sp_reg;
    logic signed [32:0] cp_reg;

    // multiplier datapath
    logic signed [65:0] prod_reg;
    logic signed [32:0] rnd_reg [NUM_PROD];

    // output registers
    logic               out_valid_reg;
    logic signed [31:0] eye_x_reg;
    logic signed [31:0] eye_y_reg;
    logic signed [31:0] eye_z_reg;
    logic        [15:0] yaw_out_reg;
    logic signed [14:0] pitch_out_reg;
    logic        [19:0] dist_out_reg;

    logic in_accept;
    logic out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // orbit update
    logic signed [32:0] spin_prod;
    logic        [15:0] yaw_next;
    logic signed [16:0] pitch_sum;
    logic signed [14:0] pitch_next;
    logic signed [21:0] dist_sum;
    logic        [19:0] dist_next;

    always_comb
    begin
        spin_prod = spin_rate_reg * $signed({1'b0, el_reg});
        // floor(spin*elapsed/1024), only the low 16 bits survive the wrap
        yaw_next  = yaw_reg + yd_reg + spin_prod[25:10];
        pitch_sum = 17'(pitch_reg) + 17'(pd_reg);
        if (pitch_sum > 17'sd16202)
            pitch_next = 15'(PITCH_LIMIT);
        else if (pitch_sum < -17'sd16202)
            pitch_next = -15'(PITCH_LIMIT);
        else
            pitch_next = pitch_sum[14:0];
        dist_sum  = $signed({2'b00, dist_reg}) + 22'(dd_reg);
        dist_next = clamp_dist(dist_sum);
    end

    // CORDIC start angle and one rotation step
    logic [31:0]        angle;
    logic               flip_next;
    logic signed [33:0] z_start;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [33:0] z_next;

    always_comb
    begin
        angle     = pass_reg ? {16'(pitch_reg), 16'h0000} : {yaw_reg, 16'h0000};
        // beyond a quarter turn either way: turn by half a turn, negate afterwards
        flip_next = angle[31] ^ angle[30];
        z_start   = 34'($signed({angle[31] ^ flip_next, angle[30:0]}));
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = $signed({2'b00, atan_turn(ATAN_IDX_W'(step_reg))});
        if (!z_reg[33])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
    end

    // multiplier operand select
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] dist_op;
    logic signed [65:0] rnd_sum;

    always_comb
    begin
        dist_op = $signed({13'd0, dist_reg});
        case (mul_cnt_reg)
            3'd0:
            begin
                mul_a = cp_reg;
                mul_b = sy_reg;
            end
            3'd1:
            begin
                mul_a = cp_reg;
                mul_b = cy_reg;
            end
            3'd2:
            begin
                mul_a = sp_reg;
                mul_b = dist_op;
            end
            3'd3:
            begin
                mul_a = rnd_reg[0];
                mul_b = dist_op;
            end
            3'd4:
            begin
                mul_a = rnd_reg[1];
                mul_b = dist_op;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        rnd_sum = prod_reg + 66'sd536870912;
    end

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;
    logic signed [33:0] sum_z;

    always_comb
    begin
        sum_x = 34'(target_x_reg) + 34'(rnd_reg[3]);
        sum_y = 34'(target_y_reg) + 34'(rnd_reg[2]);
        sum_z = 34'(target_z_reg) + 34'(rnd_reg[4]);
    end

    // sequencer, configuration, orbit state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            target_z_reg  <= '0;
            spin_rate_reg <= '0;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            dist_reg      <= 20'd10240;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            eye_x_reg     <= '0;
            eye_y_reg     <= '0;
            eye_z_reg     <= '0;
            yaw_out_reg   <= '0;
            pitch_out_reg <= '0;
            dist_out_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TARGET_X:       target_x_reg  <= cfg_data;
                    CFG_TARGET_Y:       target_y_reg  <= cfg_data;
                    CFG_TARGET_Z:       target_z_reg  <= cfg_data;
                    CFG_START_DISTANCE: dist_reg <= clamp_dist($signed({2'b00, cfg_data[19:0]}));
                    CFG_SPIN_RATE:      spin_rate_reg <= cfg_data[15:0];
                    default:            ;
                endcase
            end

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                        state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    yaw_reg   <= yaw_next;
                    pitch_reg <= pitch_next;
                    dist_reg  <= dist_next;
                    pass_reg  <= 1'b0;
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    pass_reg    <= 1'b1;
                    mul_cnt_reg <= '0;
                    state_reg   <= pass_reg ? S_MUL : S_LOAD;
                end
                S_MUL:
                begin
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == MUL_DONE)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    // hold until the output slot is free
                    if (out_free)
                    begin
                        eye_x_reg     <= sat32(sum_x);
                        eye_y_reg     <= sat32(sum_y);
                        eye_z_reg     <= sat32(sum_z);
                        yaw_out_reg   <= yaw_reg;
                        pitch_out_reg <= pitch_reg;
                        dist_out_reg  <= dist_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            yd_reg <= yaw_delta;
            pd_reg <= pitch_delta;
            dd_reg <= zoom_delta;
            el_reg <= elapsed;
        end

        case (state_reg)
            S_LOAD:
            begin
                x_reg    <= CORDIC_GAIN_INV;
                y_reg    <= '0;
                z_reg    <= z_start;
                flip_reg <= flip_next;
            end
            S_ROT:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
            S_STORE:
            begin
                if (!pass_reg)
                begin
                    sy_reg <= flip_reg ? 33'(-y_reg) : y_reg[32:0];
                    cy_reg <= flip_reg ? 33'(-x_reg) : x_reg[32:0];
                end
                else
                begin
                    sp_reg <= flip_reg ? 33'(-y_reg) : y_reg[32:0];
                    cp_reg <= flip_reg ? 33'(-x_reg) : x_reg[32:0];
                end
            end
            S_MUL:
            begin
                // issue one product, retire the previous one rounded by 2^30 (Q2.30 for cp*sy and cp*cy)
                prod_reg <= mul_a * mul_b;
                if (mul_cnt_reg != 3'd0)
                    rnd_reg[mul_cnt_reg - 3'd1] <= rnd_sum[62:30];
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign eye_x        = eye_x_reg;
    assign eye_y        = eye_y_reg;
    assign eye_z        = eye_z_reg;
    assign yaw_now      = yaw_out_reg;
    assign pitch_now    = pitch_out_reg;
    assign distance_now = dist_out_reg;

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import ocam_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = 2 * STEPS + 12;
    localparam int HOLD_CYCLES = 400;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int PHASES = 6;
    localparam int PHASE_MOVES = 150;
    localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CFG_LAST_CODE = 3'd7;
    localparam longint EYE_MAX = (longint'(1) <<< 31) - 1;
    localparam longint EYE_MIN = -(longint'(1) <<< 31);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [15:0] yaw;
        logic signed [14:0] pitch;
        logic        [19:0] radius;
    } eye_pose_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] yaw_delta;
    logic signed [15:0] pitch_delta;
    logic signed [20:0] zoom_delta;
    logic        [15:0] elapsed;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic        [15:0] yaw_now;
    logic signed [14:0] pitch_now;
    logic        [19:0] distance_now;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [2:0]  cfg_index;
    logic        [31:0] cfg_data;

    // camera state and registers as the block should hold them
    logic        [15:0] cam_yaw = '0;
    int                 cam_pitch = 0;
    int                 cam_dist = 10240;
    logic signed [31:0] aim_x = '0;
    logic signed [31:0] aim_y = '0;
    logic signed [31:0] aim_z = '0;
    logic signed [15:0] spin_per_s = '0;

    // arctan(2^-i), 2^32 per turn
    longint arctan_table [ATAN_LEN] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    eye_pose_t pose_expect [$];
    int        mismatch_count = 0;
    int        results_checked = 0;
    int        reg_writes = 0;
    bit        idle_on = 1'b1;
    bit        holding = 1'b0;
    int        hold_request = 0;

    orbit_camera_eye_position_top #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .yaw_delta(yaw_delta),
        .pitch_delta(pitch_delta),
        .zoom_delta(zoom_delta),
        .elapsed(elapsed),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .eye_x(eye_x),
        .eye_y(eye_y),
        .eye_z(eye_z),
        .yaw_now(yaw_now),
        .pitch_now(pitch_now),
        .distance_now(distance_now),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint round_q30(input longint a, input longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic void cordic_sin_cos(input logic [31:0] angle, output longint sn,
                                           output longint cs);
        logic [31:0] a;
        logic [31:0] shifted;
        logic        flip;
        longint      px;
        longint      py;
        longint      pz;
        longint      dx;
        longint      dy;
        a = angle;
        shifted = a + 32'h4000_0000;
        // fold angles past a quarter turn onto the front half
        flip = shifted[31];
        if (flip)
            a = a - 32'h8000_0000;
        px = longint'(CORDIC_GAIN_INV);
        py = 0;
        pz = longint'($signed(a));
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++)
        begin
            dx = py >>> i;
            dy = px >>> i;
            if (pz >= 0)
            begin
                px = px - dx;
                py = py + dy;
                pz = pz - arctan_table[i];
            end
            else
            begin
                px = px + dx;
                py = py - dy;
                pz = pz + arctan_table[i];
            end
        end
        if (flip)
        begin
            px = -px;
            py = -py;
        end
        sn = py;
        cs = px;
    endfunction

    function automatic eye_pose_t orbit_step(input logic signed [15:0] yd,
                                             input logic signed [15:0] pd,
                                             input logic signed [20:0] dd,
                                             input logic [15:0] el);
        eye_pose_t   p;
        longint      spin;
        longint      sy;
        longint      cy;
        longint      sp;
        longint      cp;
        longint      ox;
        longint      oy;
        longint      oz;
        logic [31:0] pitch_bits;
        spin = (longint'(spin_per_s) * longint'(el)) >>> 10;
        cam_yaw = 16'(longint'(cam_yaw) + longint'(yd) + spin);
        cam_pitch = int'(clamp_range(longint'(cam_pitch) + longint'(pd),
                                     -PITCH_LIMIT, PITCH_LIMIT));
        cam_dist = int'(clamp_range(longint'(cam_dist) + longint'(dd), DIST_MIN, DIST_MAX));
        pitch_bits = cam_pitch;
        cordic_sin_cos({cam_yaw, 16'h0000}, sy, cy);
        cordic_sin_cos({pitch_bits[15:0], 16'h0000}, sp, cp);
        ox = round_q30(round_q30(cp, sy), cam_dist);
        oy = round_q30(sp, cam_dist);
        oz = round_q30(round_q30(cp, cy), cam_dist);
        p.x = 32'(clamp_range(longint'(aim_x) + ox, EYE_MIN, EYE_MAX));
        p.y = 32'(clamp_range(longint'(aim_y) + oy, EYE_MIN, EYE_MAX));
        p.z = 32'(clamp_range(longint'(aim_z) + oz, EYE_MIN, EYE_MAX));
        p.yaw = cam_yaw;
        p.pitch = 15'(cam_pitch);
        p.radius = 20'(cam_dist);
        return p;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic logic [31:0] pick_target();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'(int'($urandom_range(0, 4194303)) - 2097152);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        eye_pose_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pose_expect.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no request pending, expected none, actual eye %0d %0d %0d",
                         $time, eye_x, eye_y, eye_z);
            end
            else
            begin
                want = pose_expect.pop_front();
                compare_field("eye_x", longint'(want.x), longint'(eye_x));
                compare_field("eye_y", longint'(want.y), longint'(eye_y));
                compare_field("eye_z", longint'(want.z), longint'(eye_z));
                compare_field("yaw_now", longint'(want.yaw), longint'(yaw_now));
                compare_field("pitch_now", longint'(want.pitch), longint'(pitch_now));
                compare_field("distance_now", longint'(want.radius), longint'(distance_now));
            end
        end
        if (rst_n && in_valid && !in_stall)
            pose_expect.push_back(orbit_step(yaw_delta, pitch_delta, zoom_delta, elapsed));
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TARGET_X: aim_x = cfg_data;
                CFG_TARGET_Y: aim_y = cfg_data;
                CFG_TARGET_Z: aim_z = cfg_data;
                CFG_START_DISTANCE:
                    cam_dist = int'(clamp_range(longint'(cfg_data[19:0]), DIST_MIN, DIST_MAX));
                CFG_SPIN_RATE: spin_per_s = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    initial
    begin : result_sink
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                holding = 1'b1;
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                holding = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_move(input logic signed [15:0] yd, input logic signed [15:0] pd,
                             input logic signed [20:0] dd, input logic [15:0] el);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        yaw_delta <= yd;
        pitch_delta <= pd;
        zoom_delta <= dd;
        elapsed <= el;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_move();
        logic signed [15:0] yd;
        logic signed [15:0] pd;
        logic signed [20:0] dd;
        logic        [15:0] el;
        int                 roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
        begin
            yd = 16'($urandom);
            pd = 16'($urandom);
            dd = 21'($urandom);
            el = 16'($urandom);
        end
        else if (roll < 9)
        begin
            // small steps move pitch and distance in short strides rather than jumping to their limits
            yd = 16'(int'($urandom_range(0, 8191)) - 4096);
            pd = 16'(int'($urandom_range(0, 3999)) - 2000);
            dd = 21'(int'($urandom_range(0, 40959)) - 20480);
            el = 16'($urandom_range(0, 2047));
        end
        else
        begin
            yd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            pd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            dd = $urandom_range(0, 1) ? 21'sh0FFFFF : 21'sh100000;
            el = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        send_move(yd, pd, dd, el);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pose_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // keep valid up when another write follows in the next cycle
        if (last)
            cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic test_reset_state();
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0000);
        wait_all_results();
    endtask

    task automatic test_field_extremes();
        send_move(16'sh7FFF, 16'sh7FFF, 21'sh0FFFFF, 16'hFFFF);
        send_move(16'sh7FFF, 16'sh0000, 21'sh000000, 16'h0000);
        // wrap yaw through zero
        send_move(16'sh0002, 16'sh0000, 21'sh000000, 16'h0000);
        send_move(16'sh8000, 16'sh8000, 21'sh100000, 16'h0000);
        send_move(16'sh0000, 16'sd16202, 21'sh000000, 16'h0000);
        send_move(16'sh0000, 16'sd16202, 21'sh000000, 16'h0000);
        send_move(16'sh0000, 16'sh0001, 21'sh000001, 16'h0000);
        wait_all_results();
    endtask

    task automatic test_config_registers();
        write_reg(CFG_SPIN_RATE, 32'hABCD_7FFF, 1'b1);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'hFFFF);
        wait_all_results();
        // negative spin below one unit must floor to -1
        write_reg(CFG_SPIN_RATE, 32'h0000_FFFF, 1'b1);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0001);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0400);
        wait_all_results();
        write_reg(CFG_SPIN_RATE, 32'h0000_0001, 1'b1);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h03FF);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0400);
        wait_all_results();
        write_reg(CFG_SPIN_RATE, 32'h0000_8000, 1'b1);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0003);
        wait_all_results();
        // start distance reloads the orbit distance, clamped
        write_reg(CFG_START_DISTANCE, 32'h0000_0000, 1'b1);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0000);
        wait_all_results();
        write_reg(CFG_START_DISTANCE, 32'h000F_FFFF, 1'b1);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0000);
        wait_all_results();
        write_reg(CFG_START_DISTANCE, 32'hFFF0_0033, 1'b1);
        send_move(16'sh0000, 16'sh0000, 21'sh000000, 16'h0000);
        wait_all_results();
        // far orbit around a corner target: saturate high, then low
        write_reg(CFG_START_DISTANCE, 32'(DIST_MAX), 1'b0);
        write_reg(CFG_SPIN_RATE, 32'h0000_0000, 1'b0);
        write_reg(CFG_TARGET_X, 32'h7FFF_FFFF, 1'b0);
        write_reg(CFG_TARGET_Y, 32'h7FFF_FFFF, 1'b0);
        write_reg(CFG_TARGET_Z, 32'h7FFF_FFFF, 1'b1);
        send_move(16'h2000 - cam_yaw, 16'sh7FFF, 21'sh000000, 16'h0000);
        wait_all_results();
        write_reg(CFG_TARGET_X, 32'h8000_0000, 1'b0);
        write_reg(CFG_TARGET_Y, 32'h8000_0000, 1'b0);
        write_reg(CFG_TARGET_Z, 32'h8000_0000, 1'b1);
        send_move(16'hA000 - cam_yaw, 16'sh8000, 21'sh000000, 16'h0000);
        wait_all_results();
        // writes to unused indexes must leave everything alone
        for (int k = CFG_FIRST_UNUSED; k <= CFG_LAST_CODE; k++)
            write_reg(3'(k), $urandom, k == CFG_LAST_CODE);
        send_move(16'sh0100, 16'sh0100, 21'sh000400, 16'h0000);
        wait_all_results();
    endtask

    task automatic test_backpressure();
        hold_request = HOLD_CYCLES;
        wait (holding);
        repeat (12) send_random_move();
        wait_all_results();
        repeat (6) send_random_move();
        wait_all_results();
    endtask

    task automatic test_random_orbits();
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
        logic [19:0] sd;
        logic [15:0] sr;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_all_results();
            case (phase)
                1:
                begin
                    tx = 32'h7FFF_FFFF;
                    ty = 32'h7FFF_FFFF;
                    tz = 32'h7FFF_FFFF;
                    sd = 20'(DIST_MAX);
                    sr = 16'h7FFF;
                end
                2:
                begin
                    tx = 32'h8000_0000;
                    ty = 32'h8000_0000;
                    tz = 32'h8000_0000;
                    sd = 20'(DIST_MIN);
                    sr = 16'h8000;
                end
                default:
                begin
                    tx = pick_target();
                    ty = pick_target();
                    tz = pick_target();
                    sd = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                      : 20'($urandom_range(DIST_MIN, 40960));
                    sr = 16'($urandom);
                end
            endcase
            write_reg(CFG_TARGET_X, tx, 1'b0);
            write_reg(CFG_TARGET_Y, ty, 1'b0);
            write_reg(CFG_TARGET_Z, tz, 1'b0);
            write_reg(CFG_START_DISTANCE, {12'($urandom), sd}, 1'b0);
            write_reg(CFG_SPIN_RATE, {16'($urandom), sr}, 1'b1);
            // run the last phase with both sides streaming
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            repeat (PHASE_MOVES) send_random_move();
        end
        wait_all_results();
    endtask

    initial
    begin : stimulus
        in_valid <= 1'b0;
        yaw_delta <= '0;
        pitch_delta <= '0;
        zoom_delta <= '0;
        elapsed <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_config_registers();
        test_backpressure();
        test_random_orbits();

        repeat (LATENCY + 8) @(posedge clk);
        $display("Checked %0d eye positions across %0d register writes: pitch and distance clamps,",
                 results_checked, reg_writes);
        $display("yaw wrap, spin flooring, target saturation and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatch_count > 0)
            $display("%0d mismatches in total", mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

endmodule
